FILE: design/ihq_pkg.sv
// shared types and codes for the indexed min-heap queue
// no dependencies; used by the top level through scoped names
package ihq_pkg;

    // operation codes carried in the mode field
    localparam logic [2:0] MODE_PUSH   = 3'd0;
    localparam logic [2:0] MODE_POP    = 3'd1;
    localparam logic [2:0] MODE_REMOVE = 3'd2;
    localparam logic [2:0] MODE_GET    = 3'd3;
    localparam logic [2:0] MODE_PEEK   = 3'd4;

    // status codes of a result word
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_EMPTY  = 2'd1;
    localparam logic [1:0] STATUS_ABSENT = 2'd2;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_POS_WAIT,
        S_ENTRY_WAIT,
        S_TOP_WAIT,
        S_LAST_WAIT,
        S_UP,
        S_UP_WAIT,
        S_DOWN,
        S_DOWN_L,
        S_DOWN_R,
        S_DOWN_MV,
        S_DOWN_END,
        S_WRITE,
        S_DONE
    } t_state;

endpackage

FILE: design/ihq_ram.sv
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module ihq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/indexed_min_heap_queue_top.sv
// indexed min-heap queue: heap ram of {key, priority}, key-to-slot ram, sequencer
// depends on ihq_pkg and ihq_ram
// errors and unused modes go straight to done, peek reads the root, get reads the slot
// then the entry, a new key climbs by parent reads, descent reads left then right child
// per level; one word at a time, start taken only while busy is low; reset is
// synchronous, empties the queue and clears the presence bits; no receiver stall
module indexed_min_heap_queue_top #(
    parameter int KEY_BITS      = 8,
    parameter int PRIORITY_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [2:0]               i_mode,
    input  logic [KEY_BITS-1:0]      i_item_key,
    input  logic [PRIORITY_BITS-1:0] i_priority_req,
    output logic                     o_done,
    output logic [1:0]               o_status,
    output logic [KEY_BITS-1:0]      o_result_key,
    output logic [PRIORITY_BITS-1:0] o_result_priority,
    output logic [KEY_BITS:0]        o_occupancy
);

    localparam int KB  = KEY_BITS;
    localparam int PB  = PRIORITY_BITS;
    localparam int CAP = 1 << KB;
    localparam int HW  = KB + PB;

    ihq_pkg::t_state r_state, n_state;

    logic [2:0]    r_mode, n_mode;
    logic [KB-1:0] r_key, n_key;
    logic [PB-1:0] r_prio, n_prio;
    logic [KB-1:0] r_ekey, n_ekey;
    logic [PB-1:0] r_eprio, n_eprio;
    logic [KB-1:0] r_ckey, n_ckey;
    logic [PB-1:0] r_cprio, n_cprio;
    logic [KB-1:0] r_cidx, n_cidx;
    logic [KB-1:0] r_idx, n_idx;
    logic [KB:0]   r_count, n_count;
    logic [CAP-1:0] r_present, n_present;
    logic          r_then_up, n_then_up;
    logic [1:0]    r_status, n_status;
    logic [KB-1:0] r_rkey, n_rkey;
    logic [PB-1:0] r_rprio, n_rprio;

    // memory ports
    logic          heap_we, heap_re, pos_we, pos_re;
    logic [KB-1:0] heap_waddr, heap_raddr, pos_waddr, pos_raddr;
    logic [HW-1:0] heap_wdata, heap_rdata;
    logic [KB-1:0] pos_wdata, pos_rdata;

    logic [KB-1:0] hd_key;
    logic [PB-1:0] hd_prio;
    logic [KB-1:0] w_parent;
    logic [KB:0]   w_left, w_right;
    logic [PB-1:0] w_cmp_base;
    logic          w_accept;

    assign hd_key     = heap_rdata[HW-1:PB];
    assign hd_prio    = heap_rdata[PB-1:0];
    assign w_parent   = (r_idx - KB'(1)) >> 1;
    assign w_left     = {r_idx, 1'b1};
    assign w_right    = w_left + (KB+1)'(1);
    assign w_cmp_base = (r_cprio < r_eprio) ? r_cprio : r_eprio;
    assign w_accept   = start && (r_state == ihq_pkg::S_IDLE);

    ihq_ram #(.WIDTH(HW), .DEPTH(CAP)) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (heap_we),
        .i_waddr (heap_waddr),
        .i_wdata (heap_wdata),
        .i_re    (heap_re),
        .i_raddr (heap_raddr),
        .o_rdata (heap_rdata)
    );

    ihq_ram #(.WIDTH(KB), .DEPTH(CAP)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (pos_waddr),
        .i_wdata (pos_wdata),
        .i_re    (pos_re),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ihq_pkg::S_IDLE: begin
                if (start) begin
                    case (i_mode)
                        ihq_pkg::MODE_PUSH:
                            n_state = r_present[i_item_key] ? ihq_pkg::S_POS_WAIT
                                                            : ihq_pkg::S_UP;
                        ihq_pkg::MODE_POP, ihq_pkg::MODE_PEEK:
                            n_state = (r_count == '0) ? ihq_pkg::S_DONE
                                                      : ihq_pkg::S_TOP_WAIT;
                        ihq_pkg::MODE_REMOVE, ihq_pkg::MODE_GET:
                            n_state = r_present[i_item_key] ? ihq_pkg::S_POS_WAIT
                                                            : ihq_pkg::S_DONE;
                        default: n_state = ihq_pkg::S_DONE;
                    endcase
                end
            end
            ihq_pkg::S_POS_WAIT: begin
                if (r_mode == ihq_pkg::MODE_REMOVE) begin
                    n_state = ({1'b0, pos_rdata} < r_count) ? ihq_pkg::S_LAST_WAIT
                                                            : ihq_pkg::S_DONE;
                end else begin
                    n_state = ihq_pkg::S_ENTRY_WAIT;
                end
            end
            ihq_pkg::S_ENTRY_WAIT: begin
                if (r_mode == ihq_pkg::MODE_GET) begin
                    n_state = ihq_pkg::S_DONE;
                end else if (r_prio < hd_prio) begin
                    n_state = ihq_pkg::S_UP;
                end else if (r_prio > hd_prio) begin
                    n_state = ihq_pkg::S_DOWN;
                end else begin
                    n_state = ihq_pkg::S_WRITE;
                end
            end
            ihq_pkg::S_TOP_WAIT: begin
                if (r_mode == ihq_pkg::MODE_PEEK) begin
                    n_state = ihq_pkg::S_DONE;
                end else begin
                    n_state = (r_count > (KB+1)'(1)) ? ihq_pkg::S_LAST_WAIT
                                                     : ihq_pkg::S_DONE;
                end
            end
            ihq_pkg::S_LAST_WAIT: n_state = ihq_pkg::S_DOWN;
            ihq_pkg::S_UP:
                n_state = (r_idx == '0) ? ihq_pkg::S_WRITE : ihq_pkg::S_UP_WAIT;
            ihq_pkg::S_UP_WAIT:
                n_state = (hd_prio > r_eprio) ? ihq_pkg::S_UP : ihq_pkg::S_WRITE;
            ihq_pkg::S_DOWN:
                n_state = (w_left < r_count) ? ihq_pkg::S_DOWN_L : ihq_pkg::S_DOWN_END;
            ihq_pkg::S_DOWN_L:
                n_state = (w_right < r_count) ? ihq_pkg::S_DOWN_R : ihq_pkg::S_DOWN_MV;
            ihq_pkg::S_DOWN_R: n_state = ihq_pkg::S_DOWN_MV;
            ihq_pkg::S_DOWN_MV:
                n_state = (r_cprio < r_eprio) ? ihq_pkg::S_DOWN : ihq_pkg::S_DOWN_END;
            ihq_pkg::S_DOWN_END:
                n_state = r_then_up ? ihq_pkg::S_UP : ihq_pkg::S_WRITE;
            ihq_pkg::S_WRITE: n_state = ihq_pkg::S_DONE;
            ihq_pkg::S_DONE:  n_state = ihq_pkg::S_IDLE;
            default:          n_state = ihq_pkg::S_IDLE;
        endcase
    end

    // datapath next values and memory accesses
    always_comb begin
        n_mode     = r_mode;
        n_key      = r_key;
        n_prio     = r_prio;
        n_ekey     = r_ekey;
        n_eprio    = r_eprio;
        n_ckey     = r_ckey;
        n_cprio    = r_cprio;
        n_cidx     = r_cidx;
        n_idx      = r_idx;
        n_count    = r_count;
        n_present  = r_present;
        n_then_up  = r_then_up;
        n_status   = r_status;
        n_rkey     = r_rkey;
        n_rprio    = r_rprio;
        heap_we    = 1'b0;
        heap_waddr = r_idx;
        heap_wdata = {r_ekey, r_eprio};
        heap_re    = 1'b0;
        heap_raddr = '0;
        pos_we     = 1'b0;
        pos_waddr  = r_ekey;
        pos_wdata  = r_idx;
        pos_re     = 1'b0;
        pos_raddr  = i_item_key;
        case (r_state)
            ihq_pkg::S_IDLE: begin
                if (start) begin
                    n_mode    = i_mode;
                    n_key     = i_item_key;
                    n_prio    = i_priority_req;
                    n_status  = ihq_pkg::STATUS_OK;
                    n_rkey    = '0;
                    n_rprio   = '0;
                    n_then_up = 1'b0;
                    case (i_mode)
                        ihq_pkg::MODE_PUSH: begin
                            if (r_present[i_item_key]) begin
                                pos_re = 1'b1;
                            end else begin
                                n_ekey                = i_item_key;
                                n_eprio               = i_priority_req;
                                n_idx                 = r_count[KB-1:0];
                                n_count               = r_count + (KB+1)'(1);
                                n_present[i_item_key] = 1'b1;
                            end
                        end
                        ihq_pkg::MODE_POP, ihq_pkg::MODE_PEEK: begin
                            if (r_count == '0) begin
                                n_status = ihq_pkg::STATUS_EMPTY;
                            end else begin
                                heap_re = 1'b1;
                            end
                        end
                        ihq_pkg::MODE_REMOVE: begin
                            if (r_present[i_item_key]) begin
                                pos_re                = 1'b1;
                                n_present[i_item_key] = 1'b0;
                                n_count               = r_count - (KB+1)'(1);
                                n_then_up             = 1'b1;
                            end else begin
                                n_status = ihq_pkg::STATUS_ABSENT;
                            end
                        end
                        ihq_pkg::MODE_GET: begin
                            if (r_present[i_item_key]) begin
                                pos_re = 1'b1;
                            end else begin
                                n_status = ihq_pkg::STATUS_ABSENT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ihq_pkg::S_POS_WAIT: begin
                n_idx   = pos_rdata;
                heap_re = 1'b1;
                if (r_mode == ihq_pkg::MODE_REMOVE) begin
                    // the last entry fills the hole
                    heap_re    = ({1'b0, pos_rdata} < r_count);
                    heap_raddr = r_count[KB-1:0];
                end else begin
                    heap_raddr = pos_rdata;
                end
            end
            ihq_pkg::S_ENTRY_WAIT: begin
                if (r_mode == ihq_pkg::MODE_GET) begin
                    n_rprio = hd_prio;
                end else begin
                    n_ekey  = r_key;
                    n_eprio = r_prio;
                end
            end
            ihq_pkg::S_TOP_WAIT: begin
                n_rkey  = hd_key;
                n_rprio = hd_prio;
                if (r_mode == ihq_pkg::MODE_POP) begin
                    n_present[hd_key] = 1'b0;
                    n_count           = r_count - (KB+1)'(1);
                    n_idx             = '0;
                    heap_re           = (r_count > (KB+1)'(1));
                    heap_raddr        = n_count[KB-1:0];
                end
            end
            ihq_pkg::S_LAST_WAIT: begin
                n_ekey  = hd_key;
                n_eprio = hd_prio;
            end
            ihq_pkg::S_UP: begin
                heap_re    = (r_idx != '0);
                heap_raddr = w_parent;
            end
            ihq_pkg::S_UP_WAIT: begin
                // parent moves down into the current slot
                if (hd_prio > r_eprio) begin
                    heap_we    = 1'b1;
                    heap_wdata = heap_rdata;
                    pos_we     = 1'b1;
                    pos_waddr  = hd_key;
                    n_idx      = w_parent;
                end
            end
            ihq_pkg::S_DOWN: begin
                heap_re    = (w_left < r_count);
                heap_raddr = w_left[KB-1:0];
            end
            ihq_pkg::S_DOWN_L: begin
                n_ckey     = hd_key;
                n_cprio    = hd_prio;
                n_cidx     = w_left[KB-1:0];
                heap_re    = (w_right < r_count);
                heap_raddr = w_right[KB-1:0];
            end
            ihq_pkg::S_DOWN_R: begin
                // right child wins only when strictly smaller
                if (hd_prio < w_cmp_base) begin
                    n_ckey  = hd_key;
                    n_cprio = hd_prio;
                    n_cidx  = w_right[KB-1:0];
                end
            end
            ihq_pkg::S_DOWN_MV: begin
                // smaller child moves up into the current slot
                if (r_cprio < r_eprio) begin
                    heap_we    = 1'b1;
                    heap_wdata = {r_ckey, r_cprio};
                    pos_we     = 1'b1;
                    pos_waddr  = r_ckey;
                    n_idx      = r_cidx;
                end
            end
            ihq_pkg::S_DOWN_END: n_then_up = 1'b0;
            ihq_pkg::S_WRITE: begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ihq_pkg::S_IDLE;
            r_count   <= '0;
            r_present <= '0;
            r_then_up <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_present <= n_present;
            r_then_up <= n_then_up;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_key    <= n_key;
        r_prio   <= n_prio;
        r_ekey   <= n_ekey;
        r_eprio  <= n_eprio;
        r_ckey   <= n_ckey;
        r_cprio  <= n_cprio;
        r_cidx   <= n_cidx;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_rkey   <= n_rkey;
        r_rprio  <= n_rprio;
    end

    // port outputs
    always_comb begin
        busy              = (r_state != ihq_pkg::S_IDLE);
        o_done            = (r_state == ihq_pkg::S_DONE);
        o_status          = r_status;
        o_result_key      = r_rkey;
        o_result_priority = r_rprio;
        o_occupancy       = r_count;
    end

    // checks
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("accepted word did not raise busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("sequencer did not return to idle after result");
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (KB+1)'(CAP))
        else $error("occupancy beyond capacity");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ihq_pkg::STATUS_OK)) |->
        (o_result_key == '0 && o_result_priority == '0))
        else $error("error result carries data");

endmodule
